[design/salc_pkg.sv]
// Shared codes, control and status bundles for the LRU cache simulator core.
`default_nettype none

package salc_pkg;

  // access kinds
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_FETCH  = 2'd3;

  // visit outcomes
  localparam logic [1:0] OC_HIT   = 2'd0;
  localparam logic [1:0] OC_MISS  = 2'd1;
  localparam logic [1:0] OC_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_WAYS       = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic clock_tick;
    logic row_read;
    logic scan_issue;
    logic resolve;
    logic visit_last;
  } salc_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic clear_done;
    logic last_way;
    logic out_free;
  } salc_status_t;

endpackage

`default_nettype wire

[design/salc_ctrl.sv]
// Sequencer for the LRU cache simulator: clearing pass, accept, scan, commit.
`default_nettype none

module salc_ctrl
  import salc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [1:0]   req_type,
  output logic              in_stall,
  input  salc_status_t      st,
  output salc_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_SCAN,
    ST_DRAIN,
    ST_RES
  } state_t;

  state_t state, state_next;
  logic   more, more_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    more_next  = more;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (req_type == REQ_FETCH) begin
            cmd.clock_tick = 1'b1;
          end else begin
            more_next  = (req_type == REQ_MODIFY);
            state_next = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        cmd.row_read = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (st.last_way) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_RES;
      end
      ST_RES: begin
        if (st.out_free) begin
          cmd.resolve    = 1'b1;
          cmd.visit_last = !more;
          if (more) begin
            more_next  = 1'b0;
            state_next = ST_ROW;
          end else begin
            cmd.clock_tick = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      more  <= more_next;
    end
  end

endmodule

`default_nettype wire

[design/salc_datapath.sv]
// Line stores, way scan, LRU choice, counters and result register.
`default_nettype none

module salc_datapath
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  salc_cmd_t                  cmd,
  output salc_status_t               st,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [31:0]           address,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 outcome,
  output logic                       last,
  output logic [31:0]                hit_total,
  output logic [31:0]                miss_total,
  output logic [31:0]                eviction_total
);

  localparam int SETW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROWS  = 1 << MAX_SET_BITS;
  localparam int WAYW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW   = ($clog2(MAX_WAYS + 1) > 4) ? $clog2(MAX_WAYS + 1) : 4;
  localparam int LINEW = SETW + WAYW;
  localparam int LINES = 1 << LINEW;

  localparam logic [3:0]     MSB4   = 4'(MAX_SET_BITS);
  localparam logic [WCW-1:0] MWAYS  = WCW'(MAX_WAYS);

  // configuration
  logic [2:0] set_bits;
  logic [3:0] ways;
  logic [4:0] block_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd0;
      ways       <= 4'd1;
      block_bits <= 5'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits   <= cfg_data[2:0];
        CFG_WAYS:       ways       <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0]     eff_sb;
  logic [WCW-1:0] ways_w;
  logic [WCW-1:0] eff_ways;
  logic [5:0]     tag_shift;
  logic [31:0]    set_full;

  assign eff_sb    = ({1'b0, set_bits} > MSB4) ? MSB4 : {1'b0, set_bits};
  assign ways_w    = WCW'(ways);
  assign eff_ways  = (ways_w == '0) ? WCW'(1) : ((ways_w > MWAYS) ? MWAYS : ways_w);
  assign tag_shift = 6'(block_bits) + 6'(eff_sb);
  assign set_full  = (address >> block_bits) & ((32'd1 << eff_sb) - 32'd1);

  // latched access
  logic [SETW-1:0] req_set;
  logic [31:0]     req_tag;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_set <= set_full[SETW-1:0];
      req_tag <= tag_shift[5] ? 32'd0 : (address >> tag_shift[4:0]);
    end
  end

  // clearing pass over the valid rows
  logic [SETW-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) clr_row <= '0;
    else if (cmd.clear_step) clr_row <= clr_row + SETW'(1);
  end

  // scan bookkeeping
  logic [WAYW-1:0] rd_way;
  logic [WAYW-1:0] ev_way;
  logic            ev_en;
  logic [31:0]     tag_q;
  logic [31:0]     lu_q;
  logic [MAX_WAYS-1:0] valid_q;

  logic            hit_found, free_found, have;
  logic [WAYW-1:0] hit_way, free_way, victim_way;
  logic [31:0]     oldest;
  logic [31:0]     access_clock;
  logic [31:0]     age;

  assign age = access_clock - lu_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_en <= 1'b0;
    end else begin
      ev_en <= cmd.scan_issue;
    end
    if (cmd.row_read) rd_way <= '0;
    else if (cmd.scan_issue) rd_way <= rd_way + WAYW'(1);
    ev_way <= rd_way;
  end

  // tag and use-stamp stores: one read and one write port
  logic [31:0] tag_mem [LINES];
  logic [31:0] lu_mem  [LINES];
  logic [MAX_WAYS-1:0] valid_mem [ROWS];

  logic [1:0]      res_code;
  logic [WAYW-1:0] wr_way;

  always_comb begin
    if (hit_found) begin
      res_code = OC_HIT;
      wr_way   = hit_way;
    end else if (free_found) begin
      res_code = OC_MISS;
      wr_way   = free_way;
    end else begin
      res_code = OC_EVICT;
      wr_way   = victim_way;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      tag_q <= tag_mem[{req_set, rd_way}];
      lu_q  <= lu_mem[{req_set, rd_way}];
    end
    if (cmd.resolve) begin
      tag_mem[{req_set, wr_way}] <= req_tag;
      lu_mem[{req_set, wr_way}]  <= access_clock;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      valid_mem[clr_row] <= '0;
    end else if (cmd.resolve && (res_code == OC_MISS)) begin
      valid_mem[req_set] <= valid_q | (MAX_WAYS'(1) << free_way);
    end
    if (cmd.row_read) valid_q <= valid_mem[req_set];
  end

  // evaluate one way per cycle: first hit, first free, oldest valid
  always_ff @(posedge clk) begin
    if (rst || cmd.row_read) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      have       <= 1'b0;
    end else if (ev_en) begin
      if (valid_q[ev_way] && (tag_q == req_tag) && !hit_found) begin
        hit_found <= 1'b1;
        hit_way   <= ev_way;
      end
      if (!valid_q[ev_way] && !free_found) begin
        free_found <= 1'b1;
        free_way   <= ev_way;
      end
      if (valid_q[ev_way] && (!have || (age > oldest))) begin
        have       <= 1'b1;
        oldest     <= age;
        victim_way <= ev_way;
      end
    end
  end

  // counters and result register
  logic [31:0] hit_next, miss_next, evict_next;
  logic [31:0] hit_count, miss_count, eviction_count;

  assign hit_next   = hit_count + 32'(res_code == OC_HIT);
  assign miss_next  = miss_count + 32'(res_code != OC_HIT);
  assign evict_next = eviction_count + 32'(res_code == OC_EVICT);

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock   <= '0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.clock_tick) access_clock <= access_clock + 32'd1;
      if (cmd.resolve) begin
        hit_count      <= hit_next;
        miss_count     <= miss_next;
        eviction_count <= evict_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      outcome        <= res_code;
      last           <= cmd.visit_last;
      hit_total      <= hit_next;
      miss_total     <= miss_next;
      eviction_total <= evict_next;
    end
  end

  assign st.clear_done = (clr_row == SETW'(ROWS - 1));
  assign st.last_way   = (WCW'(rd_way) == (eff_ways - WCW'(1)));
  assign st.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

[design/set_assoc_lru_cache_sim_core.sv]
// Top level of the set-associative LRU cache simulator core.
`default_nettype none

// Tag-only cache simulator with LRU replacement. Each accepted word is one
// trace access (req_type, address); loads and stores produce one result word,
// a modify produces two (last low, then high) and an instruction fetch
// produces none, though every access advances the internal use clock. The
// address splits into block offset, set index and tag per the set_bits and
// block_bits registers, and the ways register sets the associativity; write
// them only while the core is idle. After reset a clearing pass wipes all
// 2**MAX_SET_BITS valid rows (64 by default), one set per cycle, with
// in_stall high; config writes are taken during it. Then a fetch is done
// at accept alone, while a load or store goes through a row read, a scan of
// every configured way, a drain step and a commit step, and a modify goes
// through that sequence twice. The scan is paced by the tag and use-stamp
// stores, which have one read port and are scanned one way per cycle. Results
// sit in one output register; the core keeps working on the next access
// while a result waits and holds only its commit until the register frees up.

module set_assoc_lru_cache_sim_core
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config write port
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // access words in
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            req_type,
  input  wire logic [31:0]           address,
  // result words out
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 outcome,
  output logic                       last,
  output logic [31:0]                hit_total,
  output logic [31:0]                miss_total,
  output logic [31:0]                eviction_total
);

  salc_cmd_t    cmd;
  salc_status_t st;

  // sequencer: clear, accept, scan each way, commit
  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // stores, LRU pick, counters, result register
  salc_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .address        (address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .last           (last),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

endmodule

`default_nettype wire
